// ----- sv/rmts_pkg.sv -----
// rmts_pkg: shared sizes, codes and types of the rate-monotonic tick scheduler
// used by rmts_task_table, rmts_result_buf and rate_monotonic_tick_scheduler_top
package rmts_pkg;

  localparam int unsigned MAX_TASKS = 8;
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned TIE_W     = 8;
  localparam int unsigned LOST_W    = 16;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CFG_W-1:0] TASK_COUNT_RST = 4'd8;
  // register index is the word address
  localparam logic [PADDR_W-3:0] REG_TASK_COUNT = '0;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    RSN_PRE  = 2'd0,
    RSN_LOST = 2'd1,
    RSN_FIN  = 2'd2,
    RSN_IDLE = 2'd3
  } reason_e;

  typedef struct packed {
    time_t              period;
    time_t              burst;
    time_t              rel_deadline;
    logic [TIE_W-1:0]   tie;
  } slot_static_t;

  typedef struct packed {
    time_t              next_release;
    time_t              remaining;
    time_t              abs_deadline;
    logic [LOST_W-1:0]  lost;
  } slot_dyn_t;

  typedef struct packed {
    logic               is_report;
    logic               is_idle;
    logic [SLOT_W-1:0]  task_index;
    time_t              run_ticks;
    reason_e            reason;
    logic [LOST_W-1:0]  lost_total;
    logic               killed;
  } result_t;

  // event for a run that closes, idle form when no task was running
  function automatic result_t close_result(input logic busy, input logic [IDX_W-1:0] idx,
                                           input time_t len, input reason_e rsn);
    result_t r;
    r           = '0;
    r.run_ticks = len;
    if (busy) begin
      r.task_index = SLOT_W'(idx);
      r.reason     = rsn;
    end else begin
      r.is_idle = 1'b1;
      r.reason  = RSN_IDLE;
    end
    return r;
  endfunction

endpackage

// ----- sv/rmts_task_table.sv -----
// rmts_task_table: per-slot task parameters and job state, one access port
// depends on rmts_pkg
module rmts_task_table import rmts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             st_we_i,
  input  slot_static_t     st_wdata_i,
  input  logic             dyn_we_i,
  input  slot_dyn_t        dyn_wdata_i,
  output slot_static_t     st_rdata_o,
  output slot_dyn_t        dyn_rdata_o
);

  slot_static_t             st_q   [MAX_TASKS];
  time_t                    nrel_q [MAX_TASKS];
  time_t                    rem_q  [MAX_TASKS];
  time_t                    adl_q  [MAX_TASKS];
  logic [LOST_W-1:0]        lost_q [MAX_TASKS];

  always_ff @(posedge clk_i) begin
    if (st_we_i) begin
      st_q[idx_i] <= st_wdata_i;
    end
    if (dyn_we_i) begin
      nrel_q[idx_i] <= dyn_wdata_i.next_release;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TASKS; k++) begin
        rem_q[k]  <= '0;
        adl_q[k]  <= '0;
        lost_q[k] <= '0;
      end
    end else if (dyn_we_i) begin
      rem_q[idx_i]  <= dyn_wdata_i.remaining;
      adl_q[idx_i]  <= dyn_wdata_i.abs_deadline;
      lost_q[idx_i] <= dyn_wdata_i.lost;
    end
  end

  assign st_rdata_o               = st_q[idx_i];
  assign dyn_rdata_o.next_release = nrel_q[idx_i];
  assign dyn_rdata_o.remaining    = rem_q[idx_i];
  assign dyn_rdata_o.abs_deadline = adl_q[idx_i];
  assign dyn_rdata_o.lost         = lost_q[idx_i];

endmodule

// ----- sv/rmts_result_buf.sv -----
// rmts_result_buf: holds back one result so the final one of an item gets its last flag
// depends on rmts_pkg
module rmts_result_buf import rmts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    flush_i,
  output logic    res_valid_o,
  output result_t res_data_o,
  output logic    res_last_o
);

  logic    pend_valid_q, pend_valid_d;
  result_t pend_q;
  logic    out_valid_q, out_valid_d;
  logic    out_last_q, out_last_d;
  result_t out_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    out_valid_d  = 1'b0;
    out_last_d   = 1'b0;
    if (push_i) begin
      // a newer result exists, so the held one is not the last
      out_valid_d  = pend_valid_q;
      pend_valid_d = 1'b1;
    end else if (flush_i) begin
      out_valid_d  = pend_valid_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i || flush_i) begin
      out_q <= pend_q;
    end
    if (push_i) begin
      pend_q <= push_data_i;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_q;
  assign res_last_o  = out_last_q;

endmodule

// ----- sv/rate_monotonic_tick_scheduler_top.sv -----
// rate-monotonic tick scheduler, top level with sequencer and config port
// a tick keeps busy high through the slot walk, walk exit, decide, burst update and flush,
// and no new command is taken until busy drops; a finish runs close, report walk and flush;
// a load is written while idle and busy stays low
// the last result of an item leaves in the same cycle that busy drops; results cannot be stalled
// async active-low reset clears job state, lost counts, run and tick, task_count to eight
// depends on rmts_pkg, rmts_task_table, rmts_result_buf
module rate_monotonic_tick_scheduler_top import rmts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [SLOT_W-1:0]  task_slot_i,
  input  logic [TIME_BITS-1:0] period_i,
  input  logic [TIME_BITS-1:0] burst_i,
  input  logic [TIME_BITS-1:0] rel_deadline_i,
  input  logic [TIME_BITS-1:0] first_arrival_i,
  input  logic [TIE_W-1:0]   tie_order_i,
  // results
  output logic               res_valid_o,
  output logic               is_report_o,
  output logic               is_idle_o,
  output logic [SLOT_W-1:0]  task_index_o,
  output logic [TIME_BITS-1:0] run_ticks_o,
  output logic [1:0]         reason_o,
  output logic [LOST_W-1:0]  lost_total_o,
  output logic               killed_o,
  output logic               last_o,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PASS   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_FIN    = 7'b0001000,
    S_FCLOSE = 7'b0010000,
    S_REPORT = 7'b0100000,
    S_END    = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   pick_q, pick_d;
  time_t              bp_q, bp_d;
  logic [TIE_W-1:0]   bt_q, bt_d;
  time_t              brb_q, brb_d;
  logic               run_busy_q, run_busy_d;
  logic [IDX_W-1:0]   running_q, running_d;
  time_t              run_len_q, run_len_d;
  time_t              now_q, now_d;
  logic [CFG_W-1:0]   task_count_q;

  logic [CNT_W-1:0]   cnt;
  logic               in_acc;
  logic               slot_ok;
  logic               cfg_sel;

  logic [IDX_W-1:0]   idx;
  logic               st_we, dyn_we;
  slot_static_t       st_wdata, rd_st;
  slot_dyn_t          dyn_wdata, rd_dyn;

  logic               push, flush;
  result_t            push_data, res_data;

  // slot walk datapath
  logic               rel;
  time_t              rb1, ad1, rb2, nr_n;
  logic               lost_hit;
  logic [LOST_W-1:0]  lc_n;
  logic               better;
  logic               same_run;
  time_t              rb_dec;

  assign cnt     = (32'(task_count_q) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count_q);
  assign in_acc  = start && !busy;
  assign slot_ok = 32'(task_slot_i) < MAX_TASKS;
  assign busy    = (state_q != S_IDLE);

  assign rel      = (rd_dyn.next_release == now_q);
  assign rb1      = rel ? rd_st.burst : rd_dyn.remaining;
  assign ad1      = rel ? time_t'(now_q + rd_st.rel_deadline) : rd_dyn.abs_deadline;
  assign lost_hit = (rb1 != '0) && (ad1 == now_q);
  assign rb2      = lost_hit ? '0 : rb1;
  assign lc_n     = (lost_hit && (rd_dyn.lost != '1)) ? LOST_W'(rd_dyn.lost + 1'b1)
                                                       : rd_dyn.lost;
  assign nr_n     = rel ? time_t'(now_q + rd_st.period) : rd_dyn.next_release;
  assign better   = (rb2 != '0) &&
                    (!found_q || (rd_st.period < bp_q) ||
                     ((rd_st.period == bp_q) && (rd_st.tie < bt_q)));
  assign same_run = (found_q == run_busy_q) && (!found_q || (pick_q == running_q));
  assign rb_dec   = brb_q - 1'b1;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    found_d    = found_q;
    pick_d     = pick_q;
    bp_d       = bp_q;
    bt_d       = bt_q;
    brb_d      = brb_q;
    run_busy_d = run_busy_q;
    running_d  = running_q;
    run_len_d  = run_len_q;
    now_d      = now_q;
    idx        = i_q[IDX_W-1:0];
    st_we      = 1'b0;
    dyn_we     = 1'b0;
    st_wdata.period       = period_i;
    st_wdata.burst        = burst_i;
    st_wdata.rel_deadline = rel_deadline_i;
    st_wdata.tie          = tie_order_i;
    dyn_wdata  = rd_dyn;
    push       = 1'b0;
    push_data  = '0;
    flush      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        idx = IDX_W'(task_slot_i);
        if (in_acc) begin
          unique case (mode_i)
            MODE_LOAD: begin
              if (slot_ok) begin
                st_we                  = 1'b1;
                dyn_we                 = 1'b1;
                dyn_wdata.next_release = first_arrival_i;
                dyn_wdata.remaining    = '0;
                dyn_wdata.abs_deadline = '0;
              end
            end
            MODE_TICK: begin
              state_d = S_PASS;
              i_d     = '0;
              found_d = 1'b0;
            end
            MODE_FINISH: begin
              state_d = S_FCLOSE;
            end
            MODE_NONE: begin
            end
          endcase
        end
      end

      S_PASS: begin
        if (i_q < cnt) begin
          // release, deadline check and priority compare for one slot
          dyn_we                 = 1'b1;
          dyn_wdata.next_release = nr_n;
          dyn_wdata.remaining    = rb2;
          dyn_wdata.abs_deadline = ad1;
          dyn_wdata.lost         = lc_n;
          if (lost_hit && run_busy_q && (running_q == i_q[IDX_W-1:0])) begin
            push       = (run_len_q != '0);
            push_data  = close_result(1'b1, running_q, run_len_q, RSN_LOST);
            run_busy_d = 1'b0;
            run_len_d  = '0;
          end
          if (better) begin
            found_d = 1'b1;
            pick_d  = i_q[IDX_W-1:0];
            bp_d    = rd_st.period;
            bt_d    = rd_st.tie;
            brb_d   = rb2;
          end
          i_d = CNT_W'(i_q + 1'b1);
        end else begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (same_run) begin
          if (run_len_q != '1) begin
            run_len_d = run_len_q + 1'b1;
          end
        end else begin
          push       = (run_len_q != '0);
          push_data  = close_result(run_busy_q, running_q, run_len_q, RSN_PRE);
          run_busy_d = found_q;
          running_d  = found_q ? pick_q : '0;
          run_len_d  = time_t'(1);
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        idx = pick_q;
        if (found_q) begin
          dyn_we              = 1'b1;
          dyn_wdata.remaining = rb_dec;
          if (rb_dec == '0) begin
            push       = (run_len_q != '0);
            push_data  = close_result(run_busy_q, running_q, run_len_q, RSN_FIN);
            run_busy_d = 1'b0;
            running_d  = '0;
            run_len_d  = '0;
          end
        end
        now_d   = now_q + 1'b1;
        state_d = S_END;
      end

      S_FCLOSE: begin
        push       = (run_len_q != '0);
        push_data  = close_result(run_busy_q, running_q, run_len_q, RSN_PRE);
        run_busy_d = 1'b0;
        running_d  = '0;
        run_len_d  = '0;
        i_d        = '0;
        state_d    = S_REPORT;
      end

      S_REPORT: begin
        if (i_q < cnt) begin
          push                 = 1'b1;
          push_data.is_report  = 1'b1;
          push_data.task_index = SLOT_W'(i_q[IDX_W-1:0]);
          push_data.lost_total = rd_dyn.lost;
          push_data.killed     = (rd_dyn.remaining != '0);
          i_d                  = CNT_W'(i_q + 1'b1);
        end else begin
          state_d = S_END;
        end
      end

      S_END: begin
        flush   = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      i_q        <= '0;
      found_q    <= 1'b0;
      pick_q     <= '0;
      run_busy_q <= 1'b0;
      running_q  <= '0;
      run_len_q  <= '0;
      now_q      <= '0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      found_q    <= found_d;
      pick_q     <= pick_d;
      run_busy_q <= run_busy_d;
      running_q  <= running_d;
      run_len_q  <= run_len_d;
      now_q      <= now_d;
    end
  end

  // best candidate payload
  always_ff @(posedge clk_i) begin
    bp_q  <= bp_d;
    bt_q  <= bt_d;
    brb_q <= brb_d;
  end

  // config register
  assign cfg_sel = (paddr[PADDR_W-1:2] == REG_TASK_COUNT);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? PDATA_W'(task_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= TASK_COUNT_RST;
    end else if (psel && penable && pwrite && cfg_sel) begin
      task_count_q <= pwdata[CFG_W-1:0];
    end
  end

  rmts_task_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .idx_i       (idx),
    .st_we_i     (st_we),
    .st_wdata_i  (st_wdata),
    .dyn_we_i    (dyn_we),
    .dyn_wdata_i (dyn_wdata),
    .st_rdata_o  (rd_st),
    .dyn_rdata_o (rd_dyn)
  );

  rmts_result_buf u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .flush_i     (flush),
    .res_valid_o (res_valid_o),
    .res_data_o  (res_data),
    .res_last_o  (last_o)
  );

  assign is_report_o  = res_data.is_report;
  assign is_idle_o    = res_data.is_idle;
  assign task_index_o = res_data.task_index;
  assign run_ticks_o  = res_data.run_ticks;
  assign reason_o     = res_data.reason;
  assign lost_total_o = res_data.lost_total;
  assign killed_o     = res_data.killed;

endmodule
